// ===== rtl/core/btdf_pkg.sv =====
// package for the byte to display text formatter
// register indexes, display modes, character constants and the control name table
// no dependencies
`timescale 1ns / 1ps

package btdf_pkg;

   localparam int MAX_CHARS  = 5;
   localparam int COUNT_W    = $clog2(MAX_CHARS + 1);
   localparam int NAME_COUNT = 33;
   localparam int NAME_IDX_W = $clog2(NAME_COUNT);

   localparam logic [1:0] MODE_TEXT  = 2'd0;
   localparam logic [1:0] MODE_HEX   = 2'd1;
   localparam logic [1:0] MODE_NAMES = 2'd2;

   localparam logic [1:0] REG_DISPLAY_MODE     = 2'd0;
   localparam logic [1:0] REG_SEPARATOR_ENABLE = 2'd1;
   localparam logic [1:0] REG_SEPARATOR_CHAR   = 2'd2;
   localparam logic [1:0] REG_HIDE_LINE_FEED   = 2'd3;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TILDE = 8'd126;
   localparam logic [7:0] CHAR_DEL   = 8'd127;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A_LOW = 8'h61;

   localparam logic [NAME_IDX_W-1:0] NAME_IDX_DEL = NAME_IDX_W'(32);

   // two-letter names carry a zero in the last byte
   localparam logic [23:0] NAME_TABLE [NAME_COUNT] = '{
      "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
      {"BS", 8'h00}, "TAB", {"LF", 8'h00}, {"VT", 8'h00},
      {"FF", 8'h00}, {"CR", 8'h00}, {"SO", 8'h00}, {"SI", 8'h00},
      "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
      "CAN", {"EM", 8'h00}, "SUB", "ESC",
      {"FS", 8'h00}, {"GS", 8'h00}, {"RS", 8'h00}, {"US", 8'h00},
      "DEL"
   };

   typedef struct packed {
      logic [1:0] display_mode;
      logic       separator_enable;
      logic [7:0] separator_char;
      logic       hide_line_feed;
   } cfg_type;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
   } fmt_result_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return CHAR_ZERO + {4'd0, nibble};
      end
      return CHAR_A_LOW + {4'd0, nibble} - 8'd10;
   endfunction

endpackage

// ===== rtl/core/btdf_csr.sv =====
// configuration registers on an apb-style port
// depends on btdf_pkg
`timescale 1ns / 1ps

module btdf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output btdf_pkg::cfg_type cfg
);
   import btdf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_DISPLAY_MODE:     cfg_in.display_mode     = csr_pwdata[1:0];
            REG_SEPARATOR_ENABLE: cfg_in.separator_enable = csr_pwdata[0];
            REG_SEPARATOR_CHAR:   cfg_in.separator_char   = csr_pwdata[7:0];
            REG_HIDE_LINE_FEED:   cfg_in.hide_line_feed   = csr_pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_mode     <= MODE_TEXT;
         cfg_ff.separator_enable <= 1'b0;
         cfg_ff.separator_char   <= CHAR_SPACE;
         cfg_ff.hide_line_feed   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_DISPLAY_MODE:     csr_prdata = {30'd0, cfg_ff.display_mode};
         REG_SEPARATOR_ENABLE: csr_prdata = {31'd0, cfg_ff.separator_enable};
         REG_SEPARATOR_CHAR:   csr_prdata = {24'd0, cfg_ff.separator_char};
         REG_HIDE_LINE_FEED:   csr_prdata = {31'd0, cfg_ff.hide_line_feed};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/btdf_format.sv =====
// expands one byte into its list of display characters and a character count
// depends on btdf_pkg
`timescale 1ns / 1ps

module btdf_format (
   input  logic                     [7:0] byte_in,
   input  btdf_pkg::cfg_type              cfg,
   output btdf_pkg::fmt_result_type       result
);
   import btdf_pkg::*;

   logic [NAME_IDX_W-1:0] name_idx;
   logic [23:0]           name_v;

   assign name_idx = (byte_in == CHAR_DEL) ? NAME_IDX_DEL : {1'b0, byte_in[4:0]};
   assign name_v   = NAME_TABLE[name_idx];

   always_comb begin
      result.chars = '0;
      result.count = '0;
      if (!(cfg.hide_line_feed && byte_in == CHAR_LF)) begin
         case (cfg.display_mode)
            MODE_TEXT: begin
               if ((byte_in inside {[CHAR_SPACE:CHAR_TILDE]}) || byte_in == CHAR_LF) begin
                  result.chars[0] = byte_in;
                  result.count    = COUNT_W'(1);
               end
            end
            MODE_HEX: begin
               result.chars[0] = hex_digit(byte_in[7:4]);
               result.chars[1] = hex_digit(byte_in[3:0]);
               result.count    = COUNT_W'(2);
            end
            MODE_NAMES: begin
               if (byte_in < CHAR_SPACE || byte_in == CHAR_DEL) begin
                  result.chars[0] = CHAR_HASH;
                  result.chars[1] = name_v[23:16];
                  result.chars[2] = name_v[15:8];
                  result.chars[3] = name_v[7:0];
                  result.count    = (name_v[7:0] == 8'd0) ? COUNT_W'(3) : COUNT_W'(4);
               end else begin
                  result.chars[0] = byte_in;
                  result.count    = COUNT_W'(1);
               end
            end
            default: begin
               result.count = '0;
            end
         endcase
      end
      // separator goes only after a byte that gave something
      if (result.count != '0 && cfg.separator_enable) begin
         result.chars[result.count] = cfg.separator_char;
         result.count               = result.count + COUNT_W'(1);
      end
   end

endmodule

// ===== rtl/core/btdf_serial.sv =====
// holds one byte's characters and hands them out one per cycle while rsp_tready is high, with a last mark
// depends on btdf_pkg
`timescale 1ns / 1ps

module btdf_serial (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  btdf_pkg::fmt_result_type fmt,
   output logic                     can_load,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);
   import btdf_pkg::*;

   logic [MAX_CHARS-1:0][7:0] chars_ff;
   logic [MAX_CHARS-1:0][7:0] chars_in;
   logic [COUNT_W-1:0]        remain_ff;
   logic [COUNT_W-1:0]        remain_in;
   logic                      take;

   assign rsp_tvalid = (remain_ff != '0);
   assign rsp_tdata  = chars_ff[0];
   assign rsp_tlast  = (remain_ff == COUNT_W'(1));
   assign take       = rsp_tvalid & rsp_tready;
   assign can_load   = !rsp_tvalid || (take && rsp_tlast);

   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      if (load) begin
         chars_in  = fmt.chars;
         remain_in = fmt.count;
      end else if (take) begin
         chars_in  = {8'd0, chars_ff[MAX_CHARS-1:1]};
         remain_in = remain_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

`ifndef SYNTHESIS
   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= COUNT_W'(MAX_CHARS))
      else $error("character count beyond maximum");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("load while characters still pending");

   a_step_down: assert property (@(posedge clock) disable iff (reset)
      take && !rsp_tlast && !load |=> remain_ff == $past(remain_ff) - COUNT_W'(1))
      else $error("character count did not step down");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> remain_ff == $past(fmt.count) && remain_ff != '0)
      else $error("loaded character count lost");
`endif

endmodule

// ===== rtl/core/byte_to_display_text_formatter.sv =====
// top level of the byte to display text formatter
// depends on btdf_pkg, btdf_csr, btdf_format, btdf_serial
`timescale 1ns / 1ps

// Each request carries one byte on req_tdata; the block answers with the
// display characters for it, one character per response beat, the final one
// of the byte marked by rsp_tlast. A byte gives 1 character in text or raw
// pass-through, 2 in hex, 3 or 4 for a control name (#LF, #NUL), plus 1 when
// the separator is on, so 1 to 5 characters; the output serialiser sends one
// character per cycle while rsp_tready is high. A byte that gives no
// characters (filtered in text mode, a hidden line feed, the unused mode) is
// dropped from the input register without waiting for the serialiser.
// The next request is taken while the last character of the previous byte is
// going out, so bytes stream with no gap. Configuration registers at byte
// addresses 0 display_mode, 4 separator_enable, 8 separator_char,
// 12 hide_line_feed; write them only while no byte is in flight.

module byte_to_display_text_formatter (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_out
   output logic        rsp_tlast,   // last_char
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import btdf_pkg::*;

   cfg_type        cfg;
   fmt_result_type fmt;

   // input register: one byte waiting to be expanded
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_move;
   logic       ser_load;
   logic       ser_can_load;
   logic       req_take;

   btdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btdf_format u_format (
      .byte_in (in_byte_ff),
      .cfg     (cfg),
      .result  (fmt)
   );

   // a byte with no characters leaves at once, otherwise it waits for the
   // serialiser to be free or to be sending its final character
   assign ser_load   = in_valid_ff && (fmt.count != '0) && ser_can_load;
   assign in_move    = in_valid_ff && ((fmt.count == '0) || ser_can_load);
   assign req_tready = !in_valid_ff || in_move;
   assign req_take   = req_tvalid & req_tready;

   assign in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   btdf_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (ser_load),
      .fmt        (fmt),
      .can_load   (ser_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_hidden_lf_silent: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && cfg.hide_line_feed && in_byte_ff == CHAR_LF |-> !ser_load)
      else $error("hidden line feed produced characters");

   a_byte_moves_on: assert property (@(posedge clock) disable iff (reset)
      in_move && !req_take |=> !in_valid_ff)
      else $error("input register kept a byte that moved on");

   a_hold_while_busy: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_move |=> in_valid_ff && in_byte_ff == $past(in_byte_ff))
      else $error("waiting byte lost");
`endif

endmodule

// ===== sim/byte_to_display_text_formatter_tb.sv =====
// self-checking testbench for the byte to display text formatter
// drives bytes on the request stream, checks display characters on the response stream
// depends on btdf_pkg and byte_to_display_text_formatter
`timescale 1ns / 1ps

module byte_to_display_text_formatter_tb;
   import btdf_pkg::*;

   localparam int          HALF_PERIOD   = 6;
   localparam int          RESET_CYCLES  = 8;
   localparam int          RUN_LIMIT_NS  = 2_000_000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          SEGMENTS      = 8;
   localparam int          SEGMENT_BYTES = 20;
   localparam int          REPORT_LIMIT  = 10;
   // the mode value with no meaning, which must swallow every byte
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   byte_to_display_text_formatter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // one display character as it should appear on the response stream
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } display_char_type;

   // what the checker needs to know about each request it sees accepted
   typedef struct {
      bit    typed_in;
      string text;
   } request_note_type;

   // one row of the directed table: settings, the byte, and optionally the text it must give
   typedef struct {
      logic [1:0] mode;
      logic       sep_on;
      logic [7:0] sep_char;
      logic       hide_lf;
      logic [7:0] data;
      bit         typed_in;
      string      text;
   } directed_row_type;

   // local copy of the settings, kept in step with every register write
   logic [1:0] fmt_mode     = MODE_TEXT;
   logic       fmt_sep_on   = 1'b0;
   logic [7:0] fmt_sep_char = CHAR_SPACE;
   logic       fmt_hide_lf  = 1'b0;

   string control_names [33] = '{
      "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
      "BS",  "TAB", "LF",  "VT",  "FF",  "CR",  "SO",  "SI",
      "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
      "CAN", "EM",  "SUB", "ESC", "FS",  "GS",  "RS",  "US",
      "DEL"
   };
   string hex_text = "0123456789abcdef";

   display_char_type pending_chars [$];
   request_note_type request_notes [$];

   int mismatches      = 0;
   int bytes_accepted  = 0;
   int chars_checked   = 0;
   int settings_loaded = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // expected display characters for one byte under the current settings
   function automatic int format_byte(input logic [7:0] b,
                                      output logic [7:0] chars [MAX_CHARS]);
      int    n;
      int    idx;
      string name;
      n = 0;
      foreach (chars[i]) chars[i] = 8'd0;
      if (fmt_hide_lf && b == CHAR_LF) begin
         return 0;
      end
      case (fmt_mode)
         MODE_TEXT: begin
            // printable range and line feed survive, everything else is dropped
            if ((b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_LF) begin
               chars[0] = b;
               n = 1;
            end
         end
         MODE_HEX: begin
            chars[0] = hex_text[b[7:4]];
            chars[1] = hex_text[b[3:0]];
            n = 2;
         end
         MODE_NAMES: begin
            if (b < CHAR_SPACE || b == CHAR_DEL) begin
               idx = (b == CHAR_DEL) ? 32 : int'(b);
               name = control_names[idx];
               chars[0] = CHAR_HASH;
               for (int j = 0; j < name.len(); j++) chars[1 + j] = name[j];
               n = 1 + name.len();
            end else begin
               chars[0] = b;
               n = 1;
            end
         end
         default: n = 0;
      endcase
      // separator only follows a byte that produced something
      if (n > 0 && fmt_sep_on) begin
         chars[n] = fmt_sep_char;
         n = n + 1;
      end
      return n;
   endfunction

   task automatic report_mismatch(input string what, input int exp_val, input int act_val);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s expected %02h got %02h", $realtime, what, exp_val,
                  act_val);
      end
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // checker: compares responses, then turns each accepted request into expectations
   always @(posedge clock) begin
      display_char_type exp_char;
      request_note_type note;
      logic [7:0]       chars [MAX_CHARS];
      int               n;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
               report_mismatch("unexpected char, none pending", 0, int'(rsp_tdata));
            end else begin
               exp_char = pending_chars.pop_front();
               if (rsp_tdata !== exp_char.ch) begin
                  report_mismatch("char_out", int'(exp_char.ch), int'(rsp_tdata));
               end
               if (rsp_tlast !== exp_char.last) begin
                  report_mismatch("last_char", int'(exp_char.last), int'(rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            note = request_notes.pop_front();
            if (note.typed_in) begin
               for (int k = 0; k < note.text.len(); k++) begin
                  pending_chars.push_back('{note.text[k], k == note.text.len() - 1});
               end
            end else begin
               n = format_byte(req_tdata, chars);
               for (int k = 0; k < n; k++) begin
                  pending_chars.push_back('{chars[k], k == n - 1});
               end
            end
         end
      end
   end

   // one request; the valid stays high into the next call when no idle cycle is drawn
   task automatic send_byte(input logic [7:0] b, input bit typed_in, input string text);
      request_notes.push_back('{typed_in, text});
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and let every pending character drain, plus any dropped byte in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0 || request_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write with random junk above the field, then a read back of the field
   task automatic csr_access(input logic [1:0] idx, input logic [31:0] value,
                             input int width);
      logic [31:0] field;
      field = value & ((32'd1 << width) - 32'd1);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= field | ($urandom << width);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_DISPLAY_MODE:     fmt_mode     = field[1:0];
         REG_SEPARATOR_ENABLE: fmt_sep_on   = field[0];
         REG_SEPARATOR_CHAR:   fmt_sep_char = field[7:0];
         REG_HIDE_LINE_FEED:   fmt_hide_lf  = field[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== field) begin
         report_mismatch("register read back", int'(field), int'(csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [1:0] mode, input logic sep_on,
                                input logic [7:0] sep_char, input logic hide_lf);
      csr_access(REG_DISPLAY_MODE,     {30'd0, mode},    2);
      csr_access(REG_SEPARATOR_ENABLE, {31'd0, sep_on},  1);
      csr_access(REG_SEPARATOR_CHAR,   {24'd0, sep_char}, 8);
      csr_access(REG_HIDE_LINE_FEED,   {31'd0, hide_lf}, 1);
      settings_loaded++;
   endtask

   task automatic set_idling(input int profile);
      case (profile % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
         default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
   endtask

   // bytes weighted towards control codes, line feed and delete
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0, 1, 2: return 8'($urandom_range(31));
         3:       return CHAR_LF;
         4:       return CHAR_DEL;
         5, 6:    return 8'($urandom_range(CHAR_TILDE, CHAR_SPACE));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(4))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return CHAR_SPACE;
         3:       return 8'h2C;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // directed table: first rows run on the reset settings without any write
   directed_row_type directed_rows [] = '{
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h41, 1'b1, "A"},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h20, 1'b1, " "},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h7E, 1'b1, "~"},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h0A, 1'b1, "\n"},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h00, 1'b1, ""},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h7F, 1'b1, ""},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'hFF, 1'b1, ""},
      '{MODE_TEXT,   1'b0, CHAR_SPACE, 1'b0, 8'h1F, 1'b1, ""},
      '{MODE_HEX,    1'b1, 8'h2C,      1'b0, 8'h00, 1'b1, "00,"},
      '{MODE_HEX,    1'b1, 8'h2C,      1'b0, 8'hFF, 1'b1, "ff,"},
      '{MODE_HEX,    1'b1, 8'h2C,      1'b0, 8'hA5, 1'b1, "a5,"},
      '{MODE_HEX,    1'b1, 8'h2C,      1'b0, 8'h0A, 1'b1, "0a,"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h00, 1'b1, "#NUL"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h0A, 1'b1, "#LF"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h7F, 1'b1, "#DEL"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h1F, 1'b1, "#US"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h09, 1'b1, "#TAB"},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h80, 1'b0, ""},
      '{MODE_NAMES,  1'b0, 8'h2C,      1'b0, 8'h7E, 1'b1, "~"},
      '{MODE_NAMES,  1'b1, 8'hFF,      1'b1, 8'h0A, 1'b1, ""},
      '{MODE_NAMES,  1'b1, 8'hFF,      1'b1, 8'h1B, 1'b0, ""},
      '{MODE_UNUSED, 1'b1, 8'h00,      1'b0, 8'h41, 1'b1, ""},
      '{MODE_UNUSED, 1'b1, 8'h00,      1'b0, 8'h0A, 1'b1, ""},
      '{MODE_HEX,    1'b1, 8'h00,      1'b1, 8'h0A, 1'b1, ""},
      '{MODE_HEX,    1'b1, 8'h00,      1'b1, 8'h5C, 1'b0, ""}
   };

   initial begin
      int seg;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, settings rewritten only when a row asks for new ones
      set_idling(0);
      foreach (directed_rows[r]) begin
         if (directed_rows[r].mode !== fmt_mode || directed_rows[r].sep_on !== fmt_sep_on ||
             directed_rows[r].sep_char !== fmt_sep_char ||
             directed_rows[r].hide_lf !== fmt_hide_lf) begin
            wait_idle();
            load_settings(directed_rows[r].mode, directed_rows[r].sep_on,
                          directed_rows[r].sep_char, directed_rows[r].hide_lf);
         end
         send_byte(directed_rows[r].data, directed_rows[r].typed_in, directed_rows[r].text);
      end

      // random part: fresh settings per segment, idling profile rotating with the segment
      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         case ($urandom_range(7))
            7:       load_settings(MODE_UNUSED, 1'($urandom), pick_separator(), 1'($urandom));
            default: load_settings(2'($urandom_range(2)), 1'($urandom), pick_separator(),
                                   1'($urandom));
         endcase
         set_idling(seg);
         for (int i = 0; i < SEGMENT_BYTES; i++) begin
            // mid-stream pause until every pending character is out
            if (seg == 2 && i == SEGMENT_BYTES / 2) wait_idle();
            send_byte(pick_byte(), 1'b0, "");
         end
      end

      wait_idle();
      $display("checked %0d bytes and %0d characters over %0d register settings,",
               bytes_accepted, chars_checked, settings_loaded);
      $display("all display modes, separator extremes, hidden line feed and back-pressure");
      if (mismatches == 0 && pending_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
